[design/radix_integer_to_digits_macros.svh]
`ifndef RADIX_INTEGER_TO_DIGITS_MACROS_SVH
`define RADIX_INTEGER_TO_DIGITS_MACROS_SVH

// same-cycle implication, held off during reset
`define RID_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define RID_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/rid_pkg.sv]
package rid_pkg;

    localparam int VALUE_W      = 64;
    localparam int BASE_W       = 8;
    localparam int CHAR_W       = 7;
    localparam int DIGIT_W      = 4;
    localparam int RADIX_W      = 5;
    localparam int CHUNK_W      = 8;
    localparam int QUEUE_DEPTH  = 2;

    localparam int MAX_DIGITS_DEF = 64;
    localparam int VALUE_BITS_DEF = 64;

    localparam logic [BASE_W-1:0] RADIX_MIN = BASE_W'(2);
    localparam logic [BASE_W-1:0] RADIX_MAX = BASE_W'(16);
    localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_A    = CHAR_W'(65);
    localparam logic [DIGIT_W-1:0] DEC_LIMIT = DIGIT_W'(10);

    typedef enum logic [1:0] {
        K_BAD,
        K_ZERO,
        K_NORM
    } t_kind;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [BASE_W-1:0]  base;
    } t_in;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
        logic              error;
    } t_out;

    typedef struct packed {
        t_kind              kind;
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] base;
    } t_cmd;

    // one chunk of restoring long division: {quotient chunk, remainder}
    function automatic logic [CHUNK_W+DIGIT_W-1:0] div_chunk(
        input logic [DIGIT_W-1:0] rem,
        input logic [CHUNK_W-1:0] chunk,
        input logic [RADIX_W-1:0] base
    );
        logic [RADIX_W-1:0] r;
        logic [CHUNK_W-1:0] q;
        r = {1'b0, rem};
        q = '0;
        for (int i = CHUNK_W - 1; i >= 0; i--) begin
            r = {r[DIGIT_W-1:0], chunk[i]};
            if (r >= base) begin
                r    = r - base;
                q[i] = 1'b1;
            end
        end
        return {q, r[DIGIT_W-1:0]};
    endfunction

    function automatic logic [CHAR_W-1:0] to_char(input logic [DIGIT_W-1:0] d);
        if (d < DEC_LIMIT) begin
            return CHAR_ZERO + CHAR_W'(d);
        end
        return CHAR_A + CHAR_W'(d - DEC_LIMIT);
    endfunction

endpackage

[design/radix_integer_to_digits.sv]
// Converts an unsigned value to ASCII digits in base 2 to 16, most significant first.
// Input channel: i_valid / o_ready with i_data {value, base}. Only the low VALUE_BITS
// bits of value are used. Output channel: o_valid / i_ready with o_data
// {digit_char, last, error}; last marks the final digit of a conversion.
// A base outside 2 to 16 gives one item with error set and digit_char zero;
// a zero value gives the single digit '0'.
// A two-entry command queue sits behind the input, so up to two items are taken
// while a conversion is in progress. Conversion uses one shared restoring divider
// that handles 8 bits a cycle; after the divide steps of a digit, S_PUSH stores the
// remainder as that digit on the digit stack. Once the value reaches zero, each digit
// is read back from the digit stack memory and presented through S_WAIT, S_LOAD and
// S_SEND, most significant first. Error and zero items go straight to S_SEND.
// Reset (synchronous, active low) empties the queue and drops any item in flight.
// When the receiver holds i_ready low, the current digit is held on o_data and
// conversion pauses; the input side keeps taking items until the queue is full.
module radix_integer_to_digits
    import rid_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic front_push;
    logic queue_full;
    logic queue_valid;
    logic back_ready;

    rid_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_push  (front_push),
        .o_cmd   (front_cmd),
        .i_full  (queue_full)
    );

    rid_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .i_pop   (back_ready),
        .o_cmd   (queue_cmd)
    );

    rid_back #(
        .MAX_DIGITS (MAX_DIGITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .o_ready (back_ready),
        .i_cmd   (queue_cmd),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

[design/rid_front.sv]
module rid_front
    import rid_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_push,
    output t_cmd o_cmd,
    input  logic i_full
);

    logic [VALUE_W-1:0] masked;

    assign masked  = VALUE_W'(i_data.value[VALUE_BITS-1:0]);
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_cmd.value = masked;
        o_cmd.base  = RADIX_W'(i_data.base);
        if (i_data.base < RADIX_MIN || i_data.base > RADIX_MAX) begin
            o_cmd.kind = K_BAD;
        end else if (masked == '0) begin
            o_cmd.kind = K_ZERO;
        end else begin
            o_cmd.kind = K_NORM;
        end
    end

endmodule

[design/rid_queue.sv]
module rid_queue
    import rid_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_cmd
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[design/rid_back.sv]
`include "radix_integer_to_digits_macros.svh"

module rid_back
    import rid_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    localparam int AW    = $clog2(MAX_DIGITS);
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int NB    = (VALUE_BITS + CHUNK_W - 1) / CHUNK_W;
    localparam int PAD   = NB * CHUNK_W;
    localparam int SW    = (NB > 1) ? $clog2(NB) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_PUSH,
        S_WAIT,
        S_LOAD,
        S_SEND
    } t_state;

    t_state             r_state;
    logic [PAD-1:0]     r_val;
    logic [DIGIT_W-1:0] r_rem;
    logic [SW-1:0]      r_step;
    logic [RADIX_W-1:0] r_base;
    logic [CNT_W-1:0]   r_n;
    logic [AW-1:0]      r_ptr;
    t_out               r_out;
    logic               r_out_vld;

    logic [DIGIT_W-1:0] r_stack [MAX_DIGITS];
    logic [DIGIT_W-1:0] r_rd;

    logic [CHUNK_W+DIGIT_W-1:0] div_res;
    logic [CHUNK_W-1:0]         quo;
    logic [CNT_W-1:0]           n_n;
    logic                       push_we;

    assign div_res = div_chunk(r_rem, r_val[PAD-1 -: CHUNK_W], r_base);
    assign quo     = div_res[CHUNK_W+DIGIT_W-1:DIGIT_W];
    assign n_n     = r_n + 1'b1;
    assign push_we = (r_state == S_PUSH);
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (push_we) begin
            r_stack[r_n[AW-1:0]] <= r_rem;
        end
        r_rd <= r_stack[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        unique case (i_cmd.kind)
                            K_BAD: begin
                                r_out     <= '{digit_char: '0, last: 1'b1, error: 1'b1};
                                r_out_vld <= 1'b1;
                                r_state   <= S_SEND;
                            end
                            K_ZERO: begin
                                r_out     <= '{digit_char: CHAR_ZERO, last: 1'b1, error: 1'b0};
                                r_out_vld <= 1'b1;
                                r_state   <= S_SEND;
                            end
                            K_NORM: begin
                                r_val   <= PAD'(i_cmd.value[VALUE_BITS-1:0]);
                                r_base  <= i_cmd.base;
                                r_n     <= '0;
                                r_rem   <= '0;
                                r_step  <= '0;
                                r_state <= S_DIV;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    r_val  <= (r_val << CHUNK_W) | PAD'(quo);
                    r_rem  <= div_res[DIGIT_W-1:0];
                    r_step <= r_step + 1'b1;
                    if (r_step == SW'(NB - 1)) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    r_n <= n_n;
                    if (r_val == '0) begin
                        r_ptr   <= r_n[AW-1:0];
                        r_state <= S_WAIT;
                    end else if (n_n == CNT_W'(MAX_DIGITS)) begin
                        r_out     <= '{digit_char: '0, last: 1'b1, error: 1'b1};
                        r_out_vld <= 1'b1;
                        r_state   <= S_SEND;
                    end else begin
                        r_rem   <= '0;
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_WAIT: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_out.digit_char <= to_char(r_rd);
                    r_out.last       <= (r_ptr == '0);
                    r_out.error      <= 1'b0;
                    r_out_vld        <= 1'b1;
                    r_state          <= S_SEND;
                end
                S_SEND: begin
                    if (i_ready) begin
                        r_out_vld <= 1'b0;
                        if (r_out.last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_ptr   <= r_ptr - 1'b1;
                            r_state <= S_WAIT;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `RID_ASSERT(a_err_last, o_valid && o_data.error, o_data.last, "error item without last")
    `RID_ASSERT(a_div_room, r_state == S_DIV, (r_n < CNT_W'(MAX_DIGITS)), "digit stack overrun")
    `RID_ASSERT_NEXT(a_take_busy, r_state == S_IDLE && i_valid, r_state != S_IDLE, "item not taken")
    `RID_ASSERT(a_digit_char, o_valid && !o_data.error, o_data.digit_char >= CHAR_ZERO, "bad digit")

endmodule
